FILE: design/lfpfa_pkg.sv
// Package for the lowest-first page frame allocator.
// Field widths, register map, operation and status codes, request/result structs.
// No dependencies.
`default_nettype none

package lfpfa_pkg;

  localparam int DEF_MAX_PAGES = 256;
  localparam int DEF_ID_BITS   = 16;

  localparam int MB_W  = 17;   // memory_bytes register
  localparam int PB_W  = 13;   // page_bytes register
  localparam int REQ_W = 16;
  localparam int PID_W = 16;
  localparam int IDX_IN_W = 8;
  localparam int CHG_W = 9;
  localparam int OWN_W = 16;
  localparam int ADR_W = 20;

  localparam logic [MB_W-1:0] RESET_MEM_BYTES  = MB_W'(1024);
  localparam logic [PB_W-1:0] RESET_PAGE_BYTES = PB_W'(4);

  // register index = paddr[2]
  localparam logic REG_MEM_BYTES  = 1'b0;
  localparam logic REG_PAGE_BYTES = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_IDS_OUT   = 3'd4
  } status_t;

  typedef struct packed {
    op_t                  opcode;
    logic [REQ_W-1:0]     request_bytes;
    logic [PID_W-1:0]     process_id;
    logic [IDX_IN_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [OWN_W-1:0]     assigned_id;
    logic [CHG_W-1:0]     pages_changed;
    logic [CHG_W-1:0]     free_pages;
    logic [OWN_W-1:0]     page_owner;
    logic [ADR_W-1:0]     page_address;
  } res_t;

endpackage

`default_nettype wire

FILE: design/lowest_first_page_frame_allocator.sv
// Each item takes one read pass over the owner table;
// an allocate that grants pages takes a second pass.
// One item in flight; the next is taken once the result moves to the output register.
// The owner table memory is read at one entry per cycle during a pass.
// Reset (rst_n low, synchronous) clears control; afterward a clearing pass over
// every entry zeroes the owner table, during which no input is taken.
`default_nettype none

module lowest_first_page_frame_allocator import lfpfa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // request_bytes, process_id, page_index
  input  wire logic [1:0]  in_tuser,   // opcode
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  // status, assigned_id, pages_changed, free_pages, page_owner, page_address, zero pad
  output      logic [79:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  logic [MB_W-1:0] mem_bytes_r;
  logic [PB_W-1:0] page_bytes_r;
  logic            cfg_wr;
  req_t            req;
  logic            eng_ready;
  logic            res_valid;
  logic            res_ready;
  res_t            res;
  logic            out_valid_r;
  res_t            out_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MEM_BYTES) ? 32'(mem_bytes_r) : 32'(page_bytes_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_bytes_r  <= RESET_MEM_BYTES;
      page_bytes_r <= RESET_PAGE_BYTES;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_MEM_BYTES) begin
        mem_bytes_r <= cfg_pwdata[MB_W-1:0];
      end else begin
        page_bytes_r <= cfg_pwdata[PB_W-1:0];
      end
    end
  end

  assign req.opcode        = op_t'(in_tuser);
  assign req.request_bytes = in_tdata[15:0];
  assign req.process_id    = in_tdata[31:16];
  assign req.page_index    = in_tdata[39:32];
  assign in_tready         = eng_ready;

  lfpfa_engine #(
    .MAX_PAGES (MAX_PAGES),
    .ID_BITS   (ID_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (eng_ready),
    .req        (req),
    .mem_bytes  (mem_bytes_r),
    .page_bytes (page_bytes_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.page_address, out_r.page_owner, out_r.free_pages,
                       out_r.pages_changed, out_r.assigned_id, out_r.status};

endmodule

`default_nettype wire

FILE: design/lfpfa_engine.sv
// Allocator engine: owner table memory and the sequencer that scans it.
// Depends on lfpfa_pkg.
`default_nettype none

module lfpfa_engine import lfpfa_pkg::*; #(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int ID_BITS   = DEF_ID_BITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            req_valid,
  output      logic            req_ready,
  input  wire req_t            req,
  input  wire logic [MB_W-1:0] mem_bytes,
  input  wire logic [PB_W-1:0] page_bytes,
  output      logic            res_valid,
  input  wire logic            res_ready,
  output      res_t            res
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam int ACC_W = (IDX_W + PB_W > MB_W) ? IDX_W + PB_W : MB_W;
  localparam int FB_W  = (IDX_W + PB_W + 1 > REQ_W + 1) ? IDX_W + PB_W + 1 : REQ_W + 1;
  localparam int CMP_W = (ID_BITS > PID_W) ? ID_BITS : PID_W;
  localparam int QW    = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_GRANT, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 issue_r, issue_nxt;
  logic                 proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]     proc_idx_r, proc_idx_nxt;
  logic [ACC_W-1:0]     proc_addr_r, proc_addr_nxt;
  req_t                 req_r, req_nxt;
  logic [ADR_W-1:0]     qaddr_r, qaddr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     rel_r, rel_nxt;
  logic [CNT_W-1:0]     got_r, got_nxt;
  logic [FB_W-1:0]      fb_r, fb_nxt;
  logic [FB_W-1:0]      gb_r, gb_nxt;
  logic [ID_BITS-1:0]   own_r, own_nxt;
  logic [ID_BITS-1:0]   next_id_r, next_id_nxt;
  res_t                 res_r, res_nxt;

  logic [ID_BITS-1:0]   owner_mem [MAX_PAGES];
  logic [ID_BITS-1:0]   rd_data_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [ID_BITS-1:0]   mem_wd;

  logic [PB_W-1:0]      epb;
  logic [IDX_IN_W+PB_W-1:0] qprod;
  logic                 active;
  logic                 entry_free;
  logic                 pid_hit;
  logic                 grant_hit;
  logic [ID_BITS-1:0]   next_id_inc;
  logic [CNT_W-1:0]     got_fin;

  assign epb         = (page_bytes == '0) ? PB_W'(1) : page_bytes;
  assign qprod       = (IDX_IN_W+PB_W)'(req.page_index) * (IDX_IN_W+PB_W)'(epb);
  assign active      = proc_addr_r < ACC_W'(mem_bytes);
  assign entry_free  = (rd_data_r == '0);
  assign pid_hit     = (req_r.opcode == OP_FREE) && (req_r.process_id != '0) &&
                       (CMP_W'(rd_data_r) == CMP_W'(req_r.process_id));
  assign grant_hit   = active && entry_free && (gb_r < FB_W'(req_r.request_bytes));
  assign next_id_inc = next_id_r + ID_BITS'(1);
  assign got_fin     = got_r + CNT_W'(grant_hit);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    issue_nxt     = issue_r;
    proc_vld_nxt  = proc_vld_r;
    proc_idx_nxt  = proc_idx_r;
    proc_addr_nxt = proc_addr_r;
    req_nxt       = req_r;
    qaddr_nxt     = qaddr_r;
    cnt_nxt       = cnt_r;
    rel_nxt       = rel_r;
    got_nxt       = got_r;
    fb_nxt        = fb_r;
    gb_nxt        = gb_r;
    own_nxt       = own_r;
    next_id_nxt   = next_id_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_wa        = proc_idx_r;
    mem_wd        = '0;

    // read issue shared by both passes
    if (state_r == S_SCAN || state_r == S_GRANT) begin
      proc_vld_nxt = issue_r;
      if (issue_r) begin
        proc_idx_nxt = rd_idx_r;
        if (rd_idx_r == LAST_IDX) begin
          issue_nxt = 1'b0;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end
      if (proc_vld_r) begin
        proc_addr_nxt = proc_addr_r + ACC_W'(epb);
      end
    end

    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = rd_idx_r;
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
        if (rd_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          req_nxt       = req;
          qaddr_nxt     = ADR_W'(qprod);
          rd_idx_nxt    = '0;
          issue_nxt     = 1'b1;
          proc_vld_nxt  = 1'b0;
          proc_addr_nxt = '0;
          cnt_nxt       = '0;
          rel_nxt       = '0;
          fb_nxt        = '0;
          own_nxt       = '0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (proc_vld_r) begin
          if (pid_hit) begin
            mem_we  = 1'b1;
            rel_nxt = rel_r + CNT_W'(1);
          end
          if (active && (entry_free || pid_hit)) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            fb_nxt  = fb_r + FB_W'(epb);
          end
          if (QW'(proc_idx_r) == QW'(req_r.page_index)) begin
            own_nxt = rd_data_r;
          end
          if (proc_idx_r == LAST_IDX) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        res_nxt            = '0;
        res_nxt.status     = ST_OK;
        res_nxt.free_pages = CHG_W'(cnt_r);
        state_nxt          = S_DONE;
        case (req_r.opcode)
          OP_ALLOC: begin
            if (req_r.request_bytes == '0) begin
              res_nxt.status = ST_BAD_SIZE;
            end else if (next_id_r == {ID_BITS{1'b1}}) begin
              res_nxt.status = ST_IDS_OUT;
            end else begin
              next_id_nxt         = next_id_inc;
              res_nxt.assigned_id = OWN_W'(next_id_inc);
              if (FB_W'(req_r.request_bytes) > fb_r) begin
                res_nxt.status = ST_SHORT;
              end else begin
                rd_idx_nxt    = '0;
                issue_nxt     = 1'b1;
                proc_vld_nxt  = 1'b0;
                proc_addr_nxt = '0;
                got_nxt       = '0;
                gb_nxt        = '0;
                state_nxt     = S_GRANT;
              end
            end
          end
          OP_FREE: begin
            res_nxt.status        = (rel_r == '0) ? ST_NOT_FOUND : ST_OK;
            res_nxt.pages_changed = CHG_W'(rel_r);
          end
          OP_QUERY: begin
            res_nxt.page_owner   = OWN_W'(own_r);
            res_nxt.page_address = qaddr_r;
          end
          default: begin
          end
        endcase
      end
      S_GRANT: begin
        if (proc_vld_r) begin
          if (grant_hit) begin
            mem_we = 1'b1;
            mem_wd = next_id_r;
            gb_nxt = gb_r + FB_W'(epb);
          end
          got_nxt = got_fin;
          if (proc_idx_r == LAST_IDX) begin
            res_nxt.pages_changed = CHG_W'(got_fin);
            res_nxt.free_pages    = CHG_W'(cnt_r - got_fin);
            state_nxt             = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      rd_idx_r   <= '0;
      issue_r    <= 1'b0;
      proc_vld_r <= 1'b0;
      next_id_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      issue_r    <= issue_nxt;
      proc_vld_r <= proc_vld_nxt;
      next_id_r  <= next_id_nxt;
    end
    proc_idx_r  <= proc_idx_nxt;
    proc_addr_r <= proc_addr_nxt;
    req_r       <= req_nxt;
    qaddr_r     <= qaddr_nxt;
    cnt_r       <= cnt_nxt;
    rel_r       <= rel_nxt;
    got_r       <= got_nxt;
    fb_r        <= fb_nxt;
    gb_r        <= gb_nxt;
    own_r       <= own_nxt;
    res_r       <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      owner_mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= owner_mem[rd_idx_r];
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && req_ready |=> !req_ready)
    else $error("engine took a second request while busy");

  a_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_SCAN || state_r == S_GRANT))
    else $error("owner table written outside a pass");

  a_alloc_grants: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && req_r.opcode == OP_ALLOC && res_r.status == ST_OK
      |-> res_r.pages_changed != '0 && res_r.assigned_id == OWN_W'(next_id_r))
    else $error("successful allocate granted no page");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_r))
    else $error("result changed before transfer");

endmodule

`default_nettype wire

FILE: test/lowest_first_page_frame_allocator_tb.sv
// Self-checking testbench for lowest_first_page_frame_allocator: directed and random
// allocate/free/query transfers checked against an owner-table predictor.
// Depends on lfpfa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module lowest_first_page_frame_allocator_tb;
  import lfpfa_pkg::*;

  localparam int TABLE_PAGES    = DEF_MAX_PAGES;
  localparam int TB_ID_BITS     = DEF_ID_BITS;
  localparam int ID_LIMIT       = (1 << TB_ID_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int PHASE_ITEMS    = 265;

  class frame_table_scoreboard;
    bit [OWN_W-1:0] owners [TABLE_PAGES];
    int unsigned last_id;
    int unsigned mem_bytes;
    int unsigned page_bytes;
    res_t pending_results [$];
    int errors;

    function new();
      foreach (owners[i]) owners[i] = '0;
      last_id    = 0;
      mem_bytes  = 32'(RESET_MEM_BYTES);
      page_bytes = 32'(RESET_PAGE_BYTES);
      errors     = 0;
    endfunction

    function void set_reg(logic idx, int unsigned value);
      if (idx == REG_MEM_BYTES) begin
        mem_bytes = value & 32'h1FFFF;
      end else begin
        page_bytes = value & 32'h1FFF;
      end
    endfunction

    function int unsigned unit_bytes();
      return (page_bytes == 0) ? 1 : page_bytes;
    endfunction

    function int unsigned active_pages();
      int unsigned n;
      n = (mem_bytes + unit_bytes() - 1) / unit_bytes();
      return (n > TABLE_PAGES) ? TABLE_PAGES : n;
    endfunction

    function int unsigned free_active();
      int unsigned c;
      c = 0;
      for (int i = 0; i < active_pages(); i++)
        if (owners[i] == 0) c++;
      return c;
    endfunction

    function void note_request(req_t r);
      res_t e;
      int unsigned ub, need, got, nfree;
      e     = '0;
      ub    = unit_bytes();
      nfree = free_active();
      got   = 0;
      e.status = ST_OK;
      case (r.opcode)
        OP_ALLOC: begin
          if (r.request_bytes == 0) begin
            e.status = ST_BAD_SIZE;
          end else if (last_id >= ID_LIMIT) begin
            e.status = ST_IDS_OUT;
          end else begin
            need = (int'(r.request_bytes) + ub - 1) / ub;
            last_id++;
            e.assigned_id = OWN_W'(last_id);
            if (need > nfree) begin
              e.status = ST_SHORT;
            end else begin
              for (int i = 0; i < active_pages() && got < need; i++)
                if (owners[i] == 0) begin
                  owners[i] = OWN_W'(last_id);
                  got++;
                end
              e.pages_changed = CHG_W'(got);
            end
          end
        end
        OP_FREE: begin
          if (r.process_id != 0)
            foreach (owners[i])
              if (owners[i] == r.process_id) begin
                owners[i] = '0;
                got++;
              end
          if (got == 0) e.status = ST_NOT_FOUND;
          e.pages_changed = CHG_W'(got);
        end
        OP_QUERY: begin
          e.page_owner   = owners[r.page_index];
          e.page_address = ADR_W'(int'(r.page_index) * ub);
        end
        default: ;
      endcase
      e.free_pages = CHG_W'(free_active());
      pending_results.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t want;
      int unsigned w [6];
      int unsigned g [6];
      string names [6];
      names = '{"status", "assigned_id", "pages_changed", "free_pages", "page_owner",
                "page_address"};
      g = '{got.status, got.assigned_id, got.pages_changed, got.free_pages, got.page_owner,
            got.page_address};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual status=%0d id=%0d", $time,
                 g[0], g[1]);
        return;
      end
      want = pending_results.pop_front();
      w = '{want.status, want.assigned_id, want.pages_changed, want.free_pages,
            want.page_owner, want.page_address};
      foreach (w[i])
        if (w[i] != g[i]) begin
          errors++;
          $display("%0t %s mismatch: expected %0d, actual %0d", $time, names[i], w[i], g[i]);
        end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // request_bytes, process_id, page_index
  logic [1:0]  in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  // status, assigned_id, pages_changed, free_pages, page_owner, page_address, zero pad
  logic [79:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_table_scoreboard sb;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  int quiet_cycles;

  lowest_first_page_frame_allocator #(
    .MAX_PAGES(TABLE_PAGES),
    .ID_BITS  (TB_ID_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic res_t unpack_result(logic [79:0] d);
    res_t r;
    r.status        = status_t'(d[2:0]);
    r.assigned_id   = d[18:3];
    r.pages_changed = d[27:19];
    r.free_pages    = d[36:28];
    r.page_owner    = d[52:37];
    r.page_address  = d[72:53];
    return r;
  endfunction

  function automatic req_t make_request(op_t op, int unsigned req, int unsigned pid,
                                        int unsigned idx);
    req_t r;
    r.opcode        = op;
    r.request_bytes = REQ_W'(req);
    r.process_id    = PID_W'(pid);
    r.page_index    = IDX_IN_W'(idx);
    return r;
  endfunction

  // Mostly well-formed traffic: sized allocations, frees of live owners, queries of
  // active pages; the rest is noise.
  function automatic req_t random_request();
    req_t r;
    int unsigned pick, sel, k, ub, bytes, idx, act;
    r.request_bytes = REQ_W'($urandom);
    r.process_id    = PID_W'($urandom);
    r.page_index    = IDX_IN_W'($urandom);
    ub   = sb.unit_bytes();
    act  = sb.active_pages();
    pick = $urandom_range(99);
    sel  = $urandom_range(99);
    if (pick < 45) begin
      r.opcode = OP_ALLOC;
      if (sel < 3) begin
        r.request_bytes = '0;
      end else if (sel < 88) begin
        k = $urandom_range(1, act / 4 + 1);
        bytes = (k - 1) * ub + $urandom_range(1, ub);
        r.request_bytes = (bytes > 65535) ? 16'hFFFF : REQ_W'(bytes);
      end
    end else if (pick < 75) begin
      r.opcode = OP_FREE;
      if (sel < 60) begin
        r.process_id = PID_W'(sb.last_id);
        for (int t = 0; t < 8; t++) begin
          idx = $urandom_range(TABLE_PAGES - 1);
          if (sb.owners[idx] != 0) begin
            r.process_id = sb.owners[idx];
            break;
          end
        end
      end else if (sel < 75) begin
        r.process_id = PID_W'(sb.last_id);
      end else if (sel >= 90) begin
        r.process_id = '0;
      end
    end else if (pick < 95) begin
      r.opcode = OP_QUERY;
      if (sel < 50) r.page_index = IDX_IN_W'($urandom_range((act > 0) ? act - 1 : 0));
    end else begin
      r.opcode = OP_NOP;
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r.page_index, r.process_id, r.request_bytes};
    in_tuser  <= r.opcode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic run_phase(int unsigned mem, int unsigned pb);
    settle();
    write_reg(REG_MEM_BYTES, mem);
    write_reg(REG_PAGE_BYTES, pb);
    repeat (PHASE_ITEMS) send_request(random_request());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(unpack_result(out_tdata));
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles at %0t", quiet_cycles, $time);
      $display("[lowest_first_page_frame_allocator] ERROR");
      $finish;
    end
  end

  initial begin
    sb           = new();
    in_idle_pct  = 15;
    out_idle_pct = 78;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset config: 256 pages of 4 bytes
    send_request(make_request(OP_QUERY, 16'hFFFF, 16'hFFFF, 0));
    send_request(make_request(OP_QUERY, 0, 0, 255));
    send_request(make_request(OP_ALLOC, 0, 0, 0));
    send_request(make_request(OP_ALLOC, 1, 0, 0));
    send_request(make_request(OP_ALLOC, 5, 0, 0));
    send_request(make_request(OP_ALLOC, 16'hFFFF, 0, 0));
    send_request(make_request(OP_FREE, 0, 3, 0));
    send_request(make_request(OP_FREE, 0, 0, 0));
    send_request(make_request(OP_FREE, 0, 16'hFFFF, 0));
    send_request(make_request(OP_ALLOC, 1012, 0, 0));
    send_request(make_request(OP_ALLOC, 1, 0, 0));
    send_request(make_request(OP_FREE, 0, 2, 0));
    send_request(make_request(OP_ALLOC, 8, 0, 0));
    send_request(make_request(OP_QUERY, 0, 0, 1));
    send_request(make_request(OP_NOP, 16'hFFFF, 16'hFFFF, 255));
    send_request(make_request(OP_QUERY, 0, 0, 255));

    // shrink to 10 pages with pages beyond still owned
    settle();
    write_reg(REG_MEM_BYTES, 40);
    send_request(make_request(OP_QUERY, 0, 0, 200));
    send_request(make_request(OP_ALLOC, 4, 0, 0));
    send_request(make_request(OP_FREE, 0, 4, 0));
    send_request(make_request(OP_ALLOC, 28, 0, 0));

    // zero page size acts as one byte
    settle();
    write_reg(REG_PAGE_BYTES, 0);
    send_request(make_request(OP_ALLOC, 3, 0, 0));
    send_request(make_request(OP_QUERY, 0, 0, 100));

    // no memory at all
    settle();
    write_reg(REG_MEM_BYTES, 0);
    send_request(make_request(OP_ALLOC, 1, 0, 0));
    send_request(make_request(OP_FREE, 0, 1, 0));

    run_phase(65536, 1);
    run_phase(100, 8);

    settle();
    in_idle_pct  = 78;
    out_idle_pct = 15;
    run_phase(65536, 4096);
    run_phase(1024, 4);

    settle();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    run_phase(300, 0);
    run_phase(1, 4096);

    // allocate edge cases on a full-size table of one-byte pages
    settle();
    write_reg(REG_MEM_BYTES, 65536);
    write_reg(REG_PAGE_BYTES, 1);
    send_request(make_request(OP_ALLOC, 1, 0, 0));
    send_request(make_request(OP_ALLOC, 16'hFFFF, 0, 0));
    send_request(make_request(OP_ALLOC, 0, 0, 0));
    send_request(make_request(OP_FREE, 0, sb.last_id, 0));
    send_request(make_request(OP_QUERY, 0, 0, $urandom));

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[lowest_first_page_frame_allocator] OK");
    end else begin
      $display("[lowest_first_page_frame_allocator] ERROR");
    end
    $finish;
  end

endmodule
